### rtl/vcdr_pkg.sv
// Shared types, constants and field widths for the view cone detect and rank block.
package vcdr_pkg;

  localparam int CoordW = 24;
  localparam int DeltaW = 25;
  localparam int DotW   = 16;
  localparam int ConfW  = 16;
  localparam int IdW    = 8;
  localparam int DsqW   = 51;
  localparam int RngW   = 26;
  localparam int SumW   = 44;
  localparam int ScoreW = 64;
  localparam int XyW    = 48;

  localparam logic [2:0] RegOriginX  = 3'd0;
  localparam logic [2:0] RegOriginY  = 3'd1;
  localparam logic [2:0] RegOriginZ  = 3'd2;
  localparam logic [2:0] RegForwardX = 3'd3;
  localparam logic [2:0] RegForwardY = 3'd4;
  localparam logic [2:0] RegForwardZ = 3'd5;
  localparam logic [2:0] RegMaxDist  = 3'd6;
  localparam logic [2:0] RegMinDot   = 3'd7;

  // Request from the candidate scorer to the rank store.
  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic [XyW-1:0]    loc_xy;
    logic [CoordW-1:0] loc_z;
  } cand_t;

  // True if packed score a ranks strictly before packed score b.
  function automatic logic ranks_before(input logic [ScoreW-1:0] a,
                                        input logic [ScoreW-1:0] b);
    logic r;
    if (a[63:48] != b[63:48]) r = a[63:48] > b[63:48];
    else r = a[47:24] < b[47:24];
    return r;
  endfunction

endpackage

### rtl/vcdr_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module vcdr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/vcdr_score.sv
// Candidate scorer: distance, integer square root, facing and confidence.
module vcdr_score (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [vcdr_pkg::CoordW-1:0] pos_x,
  input  logic signed [vcdr_pkg::CoordW-1:0] pos_y,
  input  logic signed [vcdr_pkg::CoordW-1:0] pos_z,
  input  logic [vcdr_pkg::IdW-1:0]          tid,
  input  logic                              keep_in,
  input  logic signed [vcdr_pkg::CoordW-1:0] origin_x,
  input  logic signed [vcdr_pkg::CoordW-1:0] origin_y,
  input  logic signed [vcdr_pkg::CoordW-1:0] origin_z,
  input  logic signed [vcdr_pkg::DotW-1:0]   forward_x,
  input  logic signed [vcdr_pkg::DotW-1:0]   forward_y,
  input  logic signed [vcdr_pkg::DotW-1:0]   forward_z,
  input  logic [vcdr_pkg::CoordW-1:0]       max_distance,
  input  logic signed [vcdr_pkg::DotW-1:0]   min_dot,
  output logic                              busy,
  output logic                              done,
  output logic                              kept,
  output vcdr_pkg::cand_t                   cand
);
  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001, S_DSQ  = 10'b0000000010, S_ACC  = 10'b0000000100,
    S_SQRT = 10'b0000001000, S_DOTD = 10'b0000010000, S_FDIV = 10'b0000100000,
    S_MD   = 10'b0001000000, S_NUM  = 10'b0010000000, S_CDIV = 10'b0100000000,
    S_DONE = 10'b1000000000
  } st_t;
  st_t state;

  logic signed [vcdr_pkg::DeltaW-1:0] dx, dy, dz;
  logic [vcdr_pkg::DsqW-1:0] rem;
  logic [vcdr_pkg::RngW-1:0] root;
  logic [4:0] step;
  logic [5:0] cnt;
  logic [1:0] phase;
  logic [vcdr_pkg::DsqW-1:0] acc;
  logic signed [vcdr_pkg::SumW-1:0] dot_s;
  logic dneg;
  logic [vcdr_pkg::SumW-1:0] dmag, dq, drem;
  logic [vcdr_pkg::DotW-1:0] facing;
  logic [63:0] num, den, cq, crem;
  logic [vcdr_pkg::IdW-1:0] id_r;
  logic [vcdr_pkg::CoordW-1:0] px, py, pz;
  logic [23:0] mm;
  logic [16:0] dd;
  logic [vcdr_pkg::SumW:0] dsub;
  logic [64:0] csub;
  logic [vcdr_pkg::DeltaW-1:0] sq_op;
  logic signed [vcdr_pkg::DeltaW-1:0] dp_op;
  logic signed [vcdr_pkg::DotW-1:0] fw_op;
  logic signed [17:0] fmd;
  logic signed [vcdr_pkg::SumW-1:0] fac_w;
  logic [23:0] rng24;

  assign busy = (state != S_IDLE);
  always_comb begin
    unique case (phase)
      2'd0: begin sq_op = dx; dp_op = dx; fw_op = forward_x; end
      2'd1: begin sq_op = dy; dp_op = dy; fw_op = forward_y; end
      default: begin sq_op = dz; dp_op = dz; fw_op = forward_z; end
    endcase
  end
  assign dsub = {drem[vcdr_pkg::SumW-2:0], dmag[vcdr_pkg::SumW-1]} - {19'b0, root};
  assign csub = {crem[63:0], num[63]} - {1'b0, den};
  assign rng24 = root[23:0];
  assign fmd = $signed({{2{facing[15]}}, facing}) - $signed({{2{min_dot[15]}}, min_dot});
  assign fac_w = dneg ? -$signed(dq) : $signed(dq);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          dx <= $signed({pos_x[23], pos_x}) - $signed({origin_x[23], origin_x});
          dy <= $signed({pos_y[23], pos_y}) - $signed({origin_y[23], origin_y});
          dz <= $signed({pos_z[23], pos_z}) - $signed({origin_z[23], origin_z});
          px <= pos_x; py <= pos_y; pz <= pos_z; id_r <= tid;
          acc <= '0; dot_s <= '0; phase <= 2'd0;
          state <= keep_in ? S_DSQ : S_DONE;
          kept <= keep_in;
        end
        S_DSQ: begin
          // One square and one dot term per cycle.
          acc <= acc + vcdr_pkg::DsqW'($signed(sq_op) * $signed(sq_op));
          dot_s <= dot_s + vcdr_pkg::SumW'($signed(fw_op) * dp_op);
          if (phase == 2'd2) state <= S_ACC;
          phase <= phase + 2'd1;
        end
        S_ACC: begin
          rem <= acc;
          root <= '0;
          step <= 5'd25;
          if (acc > vcdr_pkg::DsqW'(48'(max_distance) * 48'(max_distance))) begin
            kept <= 1'b0;
            state <= S_DONE;
          end else state <= S_SQRT;
        end
        S_SQRT: begin
          // Restoring square root, one result bit per cycle.
          if ((rem >> (2 * step)) >= vcdr_pkg::DsqW'({root, 2'b01})) begin
            rem <= rem - (vcdr_pkg::DsqW'({root, 2'b01}) << (2 * step));
            root <= {root[24:0], 1'b1};
          end else root <= {root[24:0], 1'b0};
          if (step == 5'd0) state <= S_DOTD;
          step <= step - 5'd1;
        end
        S_DOTD: begin
          dneg <= dot_s[vcdr_pkg::SumW-1];
          dmag <= dot_s[vcdr_pkg::SumW-1] ? vcdr_pkg::SumW'(-dot_s) : dot_s;
          drem <= '0; dq <= '0; cnt <= 6'd43;
          state <= S_FDIV;
        end
        S_FDIV: begin
          // Bit-serial magnitude division of the dot sum by the range.
          if (!dsub[vcdr_pkg::SumW]) begin
            drem <= dsub[vcdr_pkg::SumW-1:0];
            dq <= {dq[42:0], 1'b1};
          end else begin
            drem <= {drem[42:0], dmag[43]};
            dq <= {dq[42:0], 1'b0};
          end
          dmag <= {dmag[42:0], 1'b0};
          if (cnt == 6'd0) state <= S_MD;
          cnt <= cnt - 6'd1;
        end
        S_MD: begin
          if (root == '0) facing <= '0;
          else if (fac_w > 44'sd32767) facing <= 16'h7FFF;
          else if (fac_w < -44'sd32768) facing <= 16'h8000;
          else facing <= fac_w[15:0];
          mm <= (max_distance == '0) ? 24'd1 : max_distance;
          dd <= 17'(18'sd32768 - 18'($signed(min_dot)));
          state <= S_NUM;
        end
        S_NUM: begin
          if (fmd < 0) begin
            kept <= 1'b0;
            state <= S_DONE;
          end else begin
            num <= 64'(({40'b0, mm} - {40'b0, rng24}) * 3 * {47'b0, dd}
                   + 64'(fmd) * 2 * {40'b0, mm}) << 16;
            den <= 64'({40'b0, mm} * 5 * {47'b0, dd});
            crem <= '0; cq <= '0; cnt <= 6'd63;
            state <= S_CDIV;
          end
        end
        S_CDIV: begin
          if (!csub[64]) begin
            crem <= csub[63:0];
            cq <= {cq[62:0], 1'b1};
          end else begin
            crem <= {crem[62:0], num[63]};
            cq <= {cq[62:0], 1'b0};
          end
          num <= {num[62:0], 1'b0};
          if (cnt == 6'd0) state <= S_DONE;
          cnt <= cnt - 6'd1;
        end
        S_DONE: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cand.score  = {(cq > 64'd65535) ? 16'hFFFF : cq[15:0], rng24, facing, id_r};
  assign cand.loc_xy = {px, py};
  assign cand.loc_z  = pz;

  a_done_one: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");
  a_root_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DOTD) |-> (root[25:24] == 2'b00)) else $error("range overflow");
endmodule

### rtl/vcdr_rank.sv
// Rank store: sorted insertion into the entry memories and list emission.
module vcdr_rank #(
  parameter int MaxTargets = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ins_req,
  input  vcdr_pkg::cand_t      cand,
  input  logic                 emit_req,
  output logic                 busy,
  output logic                 out_valid,
  input  logic                 out_ready,
  output vcdr_pkg::cand_t      out_ent,
  output logic                 out_last,
  output logic                 out_empty
);
  localparam int AW = $clog2(MaxTargets);
  localparam int CW = $clog2(MaxTargets + 1);

  typedef enum logic [5:0] {
    R_IDLE = 6'b000001, R_SRCH = 6'b000010, R_SHFT = 6'b000100,
    R_EMRD = 6'b001000, R_EMOUT = 6'b010000, R_PUT = 6'b100000
  } rs_t;
  rs_t state;

  logic [CW-1:0] count, idx;
  logic [AW-1:0] raddr, waddr;
  logic we;
  vcdr_pkg::cand_t wdata, rd;
  vcdr_pkg::cand_t new_c;

  vcdr_ram #(.Width(vcdr_pkg::ScoreW), .Depth(MaxTargets)) u_sc (
    .clk, .we, .waddr, .wdata(wdata.score), .raddr, .rdata(rd.score));
  vcdr_ram #(.Width(vcdr_pkg::XyW), .Depth(MaxTargets)) u_xy (
    .clk, .we, .waddr, .wdata(wdata.loc_xy), .raddr, .rdata(rd.loc_xy));
  vcdr_ram #(.Width(vcdr_pkg::CoordW), .Depth(MaxTargets)) u_z (
    .clk, .we, .waddr, .wdata(wdata.loc_z), .raddr, .rdata(rd.loc_z));

  assign busy = (state != R_IDLE);

  // Search runs from the tail towards the head, shifting each entry that the
  // new candidate outranks one place down as it goes; the read of the entry
  // above is issued while the previous one is written, so no two accesses
  // touch the same entry in one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      count <= '0;
      out_valid <= 1'b0;
      we <= 1'b0;
    end else begin
      we <= 1'b0;
      unique case (state)
        R_IDLE: begin
          if (ins_req) begin
            new_c <= cand;
            if (count == '0) begin
              we <= 1'b1; waddr <= '0; wdata <= cand;
              count <= CW'(1);
            end else begin
              idx <= count - CW'(1);
              raddr <= AW'(count - CW'(1));
              state <= R_SHFT;
            end
          end else if (emit_req) begin
            if (count == '0) begin
              out_ent <= '0; out_last <= 1'b1; out_empty <= 1'b1;
              out_valid <= 1'b1;
              state <= R_EMOUT;
            end else begin
              idx <= '0; raddr <= '0;
              state <= R_EMRD;
            end
          end
        end
        R_SHFT: state <= R_SRCH; // read latency
        R_SRCH: begin
          if (vcdr_pkg::ranks_before(new_c.score, rd.score)) begin
            if (idx + CW'(1) < CW'(MaxTargets)) begin
              we <= 1'b1; waddr <= AW'(idx + CW'(1)); wdata <= rd;
            end
            if (idx == '0) begin
              state <= R_PUT; idx <= '0;
            end else begin
              idx <= idx - CW'(1);
              raddr <= AW'(idx - CW'(1));
              state <= R_SHFT;
            end
          end else begin
            idx <= idx + CW'(1);
            state <= R_PUT;
          end
        end
        R_PUT: begin
          if (idx < CW'(MaxTargets)) begin
            we <= 1'b1; waddr <= AW'(idx); wdata <= new_c;
          end
          if (count < CW'(MaxTargets)) count <= count + CW'(1);
          state <= R_IDLE;
        end
        R_EMRD: begin
          state <= R_EMOUT;
          out_valid <= 1'b0;
        end
        R_EMOUT: begin
          if (!out_valid) begin
            out_ent <= rd;
            out_last <= (idx + CW'(1) == count);
            out_empty <= 1'b0;
            out_valid <= 1'b1;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            if (out_empty || out_last) begin
              count <= '0;
              state <= R_IDLE;
            end else begin
              idx <= idx + CW'(1);
              raddr <= AW'(idx + CW'(1));
              state <= R_EMRD;
            end
          end
        end
        default: state <= R_IDLE;
      endcase
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (rst) count <= CW'(MaxTargets))
    else $error("count overflow");
  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == R_EMOUT)) else $error("result outside emit");
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_empty) |-> out_last) else $error("empty without last");
endmodule

### rtl/view_cone_detect_rank_unit.sv
// Top level of the view cone detect and rank block.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  input    | in_valid / in_ready    | cmd, target_id, pos_x/y/z, usable, blocked
//  result   | out_valid / out_ready  | out_id, loc_x/y/z, range, facing, ...
//  config   | cfg_we                 | cfg_index, cfg_data
//
// A target beat whose flags drop it is not scored; one beyond the distance ends
// after the squares, and one outside the cone ends after the facing division.
// A kept target passes through the squares and dot terms, the bit-serial square
// root, the facing division and the confidence division, then the sorted
// insertion, which walks the stored entries through the registered-read
// memories, so its time grows with the length of the list.
// An end beat emits one result at a time, and stalls on out_ready hold it.
// Reset loads the register defaults and clears the entry count; the memories
// are not cleared, since only entries below the count are ever read.
// Stalls on the result side hold the block; one beat is worked at a time.
module view_cone_detect_rank_unit #(
  parameter int MAX_TARGETS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [7:0]  target_id,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic signed [23:0] pos_z,
  input  logic        usable,
  input  logic        blocked,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_id,
  output logic signed [23:0] loc_x,
  output logic signed [23:0] loc_y,
  output logic signed [23:0] loc_z,
  output logic [23:0] range,
  output logic signed [15:0] facing,
  output logic [15:0] confidence,
  output logic        last,
  output logic        empty_res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  logic signed [23:0] origin_x, origin_y, origin_z;
  logic signed [15:0] forward_x, forward_y, forward_z, min_dot;
  logic [23:0] max_distance;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0; origin_y <= '0; origin_z <= '0;
      forward_x <= 16'sd32767; forward_y <= '0; forward_z <= '0;
      max_distance <= 24'd100000; min_dot <= 16'sd23170;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vcdr_pkg::RegOriginX:  origin_x <= cfg_data;
        vcdr_pkg::RegOriginY:  origin_y <= cfg_data;
        vcdr_pkg::RegOriginZ:  origin_z <= cfg_data;
        vcdr_pkg::RegForwardX: forward_x <= cfg_data[15:0];
        vcdr_pkg::RegForwardY: forward_y <= cfg_data[15:0];
        vcdr_pkg::RegForwardZ: forward_z <= cfg_data[15:0];
        vcdr_pkg::RegMaxDist:  max_distance <= cfg_data;
        vcdr_pkg::RegMinDot:   min_dot <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic sc_busy, sc_done, sc_kept, rk_busy, acc_beat, emit_q;
  vcdr_pkg::cand_t cand, ent;

  // The scorer and the store run one after another; a beat is taken only
  // when both are idle and no result from a previous beat is pending.
  assign in_ready = !sc_busy && !rk_busy && !sc_done && !emit_q;
  assign acc_beat = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) emit_q <= 1'b0;
    else emit_q <= acc_beat && cmd;
  end

  vcdr_score u_score (
    .clk, .rst, .start(acc_beat && !cmd), .pos_x, .pos_y, .pos_z,
    .tid(target_id), .keep_in(usable && !blocked),
    .origin_x, .origin_y, .origin_z, .forward_x, .forward_y, .forward_z,
    .max_distance, .min_dot, .busy(sc_busy), .done(sc_done), .kept(sc_kept),
    .cand);

  vcdr_rank #(.MaxTargets(MAX_TARGETS)) u_rank (
    .clk, .rst, .ins_req(sc_done && sc_kept), .cand, .emit_req(emit_q),
    .busy(rk_busy), .out_valid, .out_ready, .out_ent(ent), .out_last(last),
    .out_empty(empty_res));

  assign confidence = ent.score[63:48];
  assign range      = ent.score[47:24];
  assign facing     = ent.score[23:8];
  assign out_id     = ent.score[7:0];
  assign loc_x      = ent.loc_xy[47:24];
  assign loc_y      = ent.loc_xy[23:0];
  assign loc_z      = ent.loc_z;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    acc_beat |=> !(sc_done && emit_q)) else $error("overlap");
  a_ready_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while emitting");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit_q |-> !sc_busy) else $error("emit while scoring");
endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the view cone detect and rank unit: random and directed target sets, scoreboarded.

// Scoreboard: mirrors the registers and the ranked target list, and queues the expected reports.
class rank_scoreboard;
  logic signed [23:0] org_x, org_y, org_z;
  logic signed [15:0] fwd_x, fwd_y, fwd_z;
  logic [23:0] max_dist;
  logic signed [15:0] min_dot;
  logic [63:0] scores[$];
  logic [71:0] locs[$];
  logic [137:0] reports[$];
  int mismatches;
  int reports_seen;

  function new();
    org_x = 0; org_y = 0; org_z = 0;
    fwd_x = 16'sd32767; fwd_y = 0; fwd_z = 0;
    max_dist = 24'd100000; min_dot = 16'sd23170;
    mismatches = 0;
    reports_seen = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [23:0] val);
    case (idx)
      vcdr_pkg::RegOriginX:  org_x = val;
      vcdr_pkg::RegOriginY:  org_y = val;
      vcdr_pkg::RegOriginZ:  org_z = val;
      vcdr_pkg::RegForwardX: fwd_x = val[15:0];
      vcdr_pkg::RegForwardY: fwd_y = val[15:0];
      vcdr_pkg::RegForwardZ: fwd_z = val[15:0];
      vcdr_pkg::RegMaxDist:  max_dist = val;
      default:               min_dot = val[15:0];
    endcase
  endfunction

  static function logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // Notes an accepted input beat: a target is scored and ranked, an end beat queues reports.
  function void note_beat(logic cmd, logic [7:0] id, logic signed [23:0] px,
                          logic signed [23:0] py, logic signed [23:0] pz,
                          logic usable, logic blocked);
    longint dx, dy, dz, dot, fac, md, m, dd;
    logic [63:0] dsq, rng, num, den, conf, sc;
    int p;
    if (cmd) begin
      if (scores.size() == 0) begin
        reports.push_back({8'd0, 72'd0, 24'd0, 16'd0, 16'd0, 1'b1, 1'b1});
      end else begin
        foreach (scores[k])
          reports.push_back({scores[k][7:0], locs[k], scores[k][47:24], scores[k][23:8],
                             scores[k][63:48], k == scores.size() - 1, 1'b0});
        scores.delete();
        locs.delete();
      end
      return;
    end
    if (!usable || blocked) return;
    dx = longint'(px) - longint'(org_x);
    dy = longint'(py) - longint'(org_y);
    dz = longint'(pz) - longint'(org_z);
    dsq = dx * dx + dy * dy + dz * dz;
    if (dsq > {40'd0, max_dist} * {40'd0, max_dist}) return;
    rng = int_sqrt(dsq);
    if (rng == 0) begin
      fac = 0;
    end else begin
      dot = longint'(fwd_x) * dx + longint'(fwd_y) * dy + longint'(fwd_z) * dz;
      fac = dot / longint'(rng);
      if (fac > 32767) fac = 32767;
      if (fac < -32768) fac = -32768;
    end
    md = longint'(min_dot);
    if (fac < md) return;
    m = (max_dist != 0) ? longint'(max_dist) : 1;
    dd = 32768 - md;
    num = 3 * (m - longint'(rng)) * dd + 2 * (fac - md) * m;
    den = 5 * m * dd;
    conf = (num * 65536) / den;
    if (conf > 65535) conf = 65535;
    sc = {conf[15:0], rng[23:0], fac[15:0], id};
    p = 0;
    while (p < scores.size() && !vcdr_pkg::ranks_before(sc, scores[p])) p++;
    if (p >= 64) return;
    scores.insert(p, sc);
    locs.insert(p, {px, py, pz});
    if (scores.size() > 64) begin
      void'(scores.pop_back());
      void'(locs.pop_back());
    end
  endfunction

  task report(string what, logic [137:0] got, logic [137:0] want);
    $display("mismatch in %s: got %h expected %h", what, got, want);
    mismatches++;
  endtask

  // Checks one accepted report beat against the oldest expectation, field by field.
  task check_report(logic [137:0] got);
    logic [137:0] want;
    reports_seen++;
    if (reports.size() == 0) begin
      report("unexpected report", got, 138'd0);
      return;
    end
    want = reports.pop_front();
    if (got[137:130] != want[137:130]) report("out_id", got, want);
    if (got[129:106] != want[129:106]) report("loc_x", got, want);
    if (got[105:82] != want[105:82]) report("loc_y", got, want);
    if (got[81:58] != want[81:58]) report("loc_z", got, want);
    if (got[57:34] != want[57:34]) report("range", got, want);
    if (got[33:18] != want[33:18]) report("facing", got, want);
    if (got[17:2] != want[17:2]) report("confidence", got, want);
    if (got[1] != want[1]) report("last", got, want);
    if (got[0] != want[0]) report("empty_res", got, want);
  endtask
endclass

module tb_top;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic cmd = 1'b0;
  logic [7:0] target_id = '0;
  logic signed [23:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic usable = 1'b0, blocked = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_id;
  logic signed [23:0] loc_x, loc_y, loc_z;
  logic [23:0] range;
  logic signed [15:0] facing;
  logic [15:0] confidence;
  logic last, empty_res;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  rank_scoreboard board = new();

  // Idling control: bursts on either side while random_gaps is set; a long hold-off
  // of the receiver is requested through hold_cycles.
  bit random_gaps = 1'b1;
  int hold_cycles = 0;
  int targets_sent = 0, ends_sent = 0;
  int quiet_cycles = 0;
  localparam int QuietLimit = 40000;

  view_cone_detect_rank_unit DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The receiver: readiness changes at the edge; a report beat is taken when both are high.
  initial begin : receiver
    int gap;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (random_gaps && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 19);
        out_ready <= 1'b0;
        repeat (gap - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_report({out_id, loc_x, loc_y, loc_z, range, facing, confidence,
                          last, empty_res});
  end

  // Watchdog: too many cycles without a beat on either channel ends the run.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("watchdog expired with %0d reports outstanding", board.reports.size());
      $display("view_cone_detect_rank_unit regression: fail");
      $finish;
    end
  end

  // Offers one beat and holds it until accepted; the scoreboard notes it at acceptance.
  // Valid stays high into the next beat, so back-to-back beats need no gap.
  task send_beat(logic c, logic [7:0] id, logic signed [23:0] x, logic signed [23:0] y,
                 logic signed [23:0] z, logic u, logic b);
    int gap;
    cfg_we <= 1'b0;
    if (random_gaps && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c; target_id <= id; pos_x <= x; pos_y <= y; pos_z <= z;
    usable <= u; blocked <= b;
    do @(posedge clk); while (!in_ready);
    board.note_beat(c, id, x, y, z, u, b);
    if (c) ends_sent++;
    else targets_sent++;
  endtask

  task send_target(logic [7:0] id, logic signed [23:0] x, logic signed [23:0] y,
                   logic signed [23:0] z);
    send_beat(1'b0, id, x, y, z, 1'b1, 1'b0);
  endtask

  // End beat with random ignored fields.
  task send_end();
    send_beat(1'b1, 8'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
              1'($urandom), 1'($urandom));
  endtask

  // Waits for every expected report, then lets the block settle before a register write.
  task drain();
    in_valid <= 1'b0;
    while (board.reports.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    board.write_reg(idx, val);
  endtask

  // A target placed near the viewer on any side in most cases, so that many are kept.
  task send_random_target(int spread);
    logic signed [23:0] x, y, z;
    x = 24'(board.org_x + $signed($urandom_range(0, 2 * spread)) - spread);
    y = 24'(board.org_y + $signed($urandom_range(0, 2 * spread)) - spread);
    z = 24'(board.org_z + $signed($urandom_range(0, 2 * spread)) - spread);
    if ($urandom_range(0, 9) == 0) begin
      x = 24'($urandom); y = 24'($urandom); z = 24'($urandom);
    end
    send_beat(1'b0, 8'($urandom), x, y, z, $urandom_range(0, 7) != 0,
              $urandom_range(0, 7) == 0);
  endtask

  initial begin : stimulus
    int sets, n;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part with the reset settings: an empty set, flag filtering, the
    // axis extremes, a target at the origin, and exact ties in rank.
    send_end();
    send_beat(1'b0, 8'd1, 24'sd500, 24'sd0, 24'sd0, 1'b0, 1'b0);
    send_beat(1'b0, 8'd2, 24'sd500, 24'sd0, 24'sd0, 1'b1, 1'b1);
    send_target(8'd255, 24'sd1000, 24'sd10, 24'sd0);
    send_target(8'd3, 24'sd1000, 24'sd10, 24'sd0);
    send_target(8'd4, 24'sd100000, 24'sd0, 24'sd0);
    send_target(8'd5, 24'sd100001, 24'sd0, 24'sd0);
    send_target(8'd6, -24'sd8388608, -24'sd8388608, -24'sd8388608);
    send_target(8'd7, 24'sd8388607, 24'sd8388607, 24'sd8388607);
    send_target(8'd8, 24'sd0, 24'sd0, 24'sd0);
    send_target(8'd9, -24'sd500, 24'sd0, 24'sd0);
    send_end();
    drain();

    // Zero range with a non-positive cone limit, and zero max distance.
    write_reg(vcdr_pkg::RegMinDot, 24'h008000);
    write_reg(vcdr_pkg::RegMaxDist, 24'd0);
    send_target(8'd10, 24'sd0, 24'sd0, 24'sd0);
    send_target(8'd11, 24'sd1, 24'sd0, 24'sd0);
    send_end();
    drain();
    write_reg(vcdr_pkg::RegOriginX, 24'h800000);
    write_reg(vcdr_pkg::RegOriginY, 24'h7FFFFF);
    write_reg(vcdr_pkg::RegOriginZ, 24'h000000);
    write_reg(vcdr_pkg::RegForwardX, 24'h008000);
    write_reg(vcdr_pkg::RegForwardY, 24'h000000);
    write_reg(vcdr_pkg::RegForwardZ, 24'h000000);
    write_reg(vcdr_pkg::RegMaxDist, 24'hFFFFFF);
    write_reg(vcdr_pkg::RegMinDot, 24'h007FFF);
    send_target(8'd12, 24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF);
    send_target(8'd13, -24'sh800000, 24'sh7FFFFF, 24'sd0);
    send_target(8'd14, -24'sh800000, -24'sh800000, 24'sh7FFFFF);
    send_end();
    drain();

    // Random settings per set; one set with a wide cone and range fills the list
    // past its capacity, the rest are short. Set 1 applies the receiver hold-off,
    // and from set 8 on the random gaps stop.
    for (sets = 0; sets < 10; sets++) begin
      write_reg(vcdr_pkg::RegOriginX, 24'($urandom));
      write_reg(vcdr_pkg::RegOriginY, 24'($urandom));
      write_reg(vcdr_pkg::RegOriginZ, 24'($urandom));
      write_reg(vcdr_pkg::RegForwardX,
                $urandom_range(0, 1) ? 24'h007FFF : 24'($urandom));
      write_reg(vcdr_pkg::RegForwardY, 24'($urandom));
      write_reg(vcdr_pkg::RegForwardZ, 24'($urandom));
      write_reg(vcdr_pkg::RegMaxDist, $urandom_range(0, 3) == 0 ? 24'($urandom)
                                                                 : 24'($urandom_range(0, 5000)));
      write_reg(vcdr_pkg::RegMinDot, $urandom_range(0, 2) == 0 ? 24'($urandom) : 24'hFF8000);
      if (sets == 7) begin
        write_reg(vcdr_pkg::RegMaxDist, 24'hFFFFFF);
        write_reg(vcdr_pkg::RegMinDot, 24'h008000);
      end
      if (sets == 8) random_gaps = 1'b0;
      n = (sets == 7) ? 95 : $urandom_range(1, 3);
      for (int i = 0; i < n; i++) send_random_target(3000);
      send_end();
      if (sets == 1) begin
        hold_cycles = 3000;
        send_random_target(3000);
        send_end();
        send_random_target(3000);
        send_end();
      end
      drain();
    end

    repeat (200) @(posedge clk);
    $display("sent %0d targets and %0d end beats; %0d reports checked",
             targets_sent, ends_sent, board.reports_seen);
    if (board.mismatches == 0 && board.reports.size() == 0) begin
      $display("view_cone_detect_rank_unit regression: pass");
    end else begin
      $display("%0d mismatches, %0d reports missing", board.mismatches, board.reports.size());
      $display("view_cone_detect_rank_unit regression: fail");
    end
    $finish;
  end
endmodule

### view_cone_detect_rank_unit.f
rtl/vcdr_pkg.sv
rtl/vcdr_ram.sv
rtl/vcdr_score.sv
rtl/vcdr_rank.sv
rtl/view_cone_detect_rank_unit.sv
tb/tb_top.sv
